### design/fifo_with_keyed_removal_unit_assert.svh
// ----------------------------------------------------------------------------
// fifo_with_keyed_removal_unit_assert.svh
// Assertion macros for the keyed-removal FIFO. They compile to nothing in
// synthesis.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_KEYED_REMOVAL_UNIT_ASSERT_SVH
`define FIFO_WITH_KEYED_REMOVAL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FWKR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FWKR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define FWKR_ASSERT_IMPL(lbl, ante, cons, msg)
`define FWKR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### design/fwkr_pkg.sv
// ----------------------------------------------------------------------------
// fwkr_pkg
// Types, request codes and status codes of the keyed-removal FIFO.
// ----------------------------------------------------------------------------
package fwkr_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int ID_WIDTH_DEF = 16;

	typedef logic [2:0] func_t;
	typedef logic [1:0] status_t;

	localparam func_t FN_PUSH   = 3'd0;
	localparam func_t FN_POP    = 3'd1;
	localparam func_t FN_REMOVE = 3'd2;
	localparam func_t FN_QUERY  = 3'd3;
	localparam func_t FN_CLEAR  = 3'd4;

	localparam status_t STS_OK   = 2'd0;
	localparam status_t STS_MISS = 2'd1;
	localparam status_t STS_FULL = 2'd2;

endpackage

### design/fwkr_ram.sv
// ----------------------------------------------------------------------------
// fwkr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fwkr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/fifo_with_keyed_removal_unit.sv
// ----------------------------------------------------------------------------
// fifo_with_keyed_removal_unit
// Bounded FIFO of identifiers with pop, push, remove-newest-by-key, query
// and clear; one status transfer per request.
// ----------------------------------------------------------------------------
// Entries sit in one DEPTH-deep RAM used as a ring (head pointer plus count).
// Query and remove search from the newest entry back, one RAM read per cycle;
// a remove then closes the gap by moving each newer entry down one slot, one
// per cycle. The single read port of the entry RAM sets this pace.
// A new request is taken once the previous one is finished, while its result
// may still wait in the output register.
// ----------------------------------------------------------------------------
`include "fifo_with_keyed_removal_unit_assert.svh"

module fifo_with_keyed_removal_unit #(
	parameter int DEPTH    = fwkr_pkg::DEPTH_DEF,
	parameter int ID_WIDTH = fwkr_pkg::ID_WIDTH_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int IN_W  = ((ID_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((ID_WIDTH + 1 + CNT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // key_id
	input  fwkr_pkg::func_t   s_tuser,   // func
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // out_id, now_empty, fill_count
	output fwkr_pkg::status_t m_tuser    // status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_POP   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	// logical slot (0 = oldest) to RAM address
	function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
			input logic [PTR_W-1:0] ofs);
		logic [PTR_W:0] sum;
		sum = {1'b0, base} + {1'b0, ofs};
		if (sum >= (PTR_W + 1)'(DEPTH)) begin
			sum = sum - (PTR_W + 1)'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	logic [2:0]          state_q;
	fwkr_pkg::func_t     func_q;
	logic [ID_WIDTH-1:0] key_q;
	logic [PTR_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [PTR_W-1:0]    idx_q;
	logic [PTR_W-1:0]    cmp_idx_s1;
	fwkr_pkg::status_t   res_status_q;
	logic [ID_WIDTH-1:0] res_id_q;

	logic                out_vld_q;
	fwkr_pkg::status_t   out_status_q;
	logic [ID_WIDTH-1:0] out_id_q;
	logic [CNT_W-1:0]    out_cnt_q;

	logic [CNT_W-1:0]    cnt_m1;
	logic [PTR_W-1:0]    last_log;
	logic [PTR_W-1:0]    rd_log;
	logic [PTR_W-1:0]    wr_log;
	logic                ram_we;
	logic [ID_WIDTH-1:0] ram_wdata;
	logic [ID_WIDTH-1:0] ram_rdata;
	logic                hit;
	logic                out_load;

	assign cnt_m1   = count_q - CNT_W'(1);
	assign last_log = cnt_m1[PTR_W-1:0];
	assign hit      = (ram_rdata == key_q);
	assign out_load = (state_q == S_DONE) && (!out_vld_q || m_tready);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = OUT_W'({out_cnt_q, (out_cnt_q == '0), out_id_q});

	always_comb begin
		rd_log    = idx_q;
		wr_log    = count_q[PTR_W-1:0];
		ram_we    = 1'b0;
		ram_wdata = key_q;
		unique case (state_q)
			S_EXEC: begin
				if (func_q == fwkr_pkg::FN_POP) begin
					rd_log = '0;
				end else begin
					rd_log = last_log;
				end
				if (func_q == fwkr_pkg::FN_PUSH && count_q != FULL_CNT) begin
					ram_we = 1'b1;
				end
			end
			S_SCAN: begin
				rd_log = hit ? (cmp_idx_s1 + PTR_W'(1)) : idx_q;
			end
			S_SHIFT: begin
				rd_log    = idx_q + PTR_W'(2);
				wr_log    = idx_q;
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	fwkr_ram #(
		.WIDTH(ID_WIDTH),
		.DEPTH(DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(phys(head_q, wr_log)),
		.wdata(ram_wdata),
		.raddr(phys(head_q, rd_log)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (func_q)
						fwkr_pkg::FN_PUSH: begin
							if (count_q != FULL_CNT) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						fwkr_pkg::FN_POP: begin
							if (count_q != '0) begin
								state_q <= S_POP;
							end
						end
						fwkr_pkg::FN_REMOVE, fwkr_pkg::FN_QUERY: begin
							if (count_q != '0) begin
								state_q <= S_SCAN;
							end
						end
						fwkr_pkg::FN_CLEAR: begin
							count_q <= '0;
						end
						default: begin
						end
					endcase
				end
				S_POP: begin
					head_q  <= phys(head_q, PTR_W'(1));
					count_q <= cnt_m1;
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (hit) begin
						if (func_q == fwkr_pkg::FN_QUERY) begin
							state_q <= S_DONE;
						end else if (cmp_idx_s1 == last_log) begin
							count_q <= cnt_m1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SHIFT;
						end
					end else if (cmp_idx_s1 == '0) begin
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if ((idx_q + PTR_W'(1)) == last_log) begin
						count_q <= cnt_m1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= s_tuser;
				key_q  <= s_tdata[ID_WIDTH-1:0];
			end
			S_EXEC: begin
				res_id_q   <= '0;
				cmp_idx_s1 <= last_log;
				idx_q      <= last_log - PTR_W'(1);
				case (func_q)
					fwkr_pkg::FN_PUSH: begin
						res_status_q <= (count_q == FULL_CNT) ? fwkr_pkg::STS_FULL
							: fwkr_pkg::STS_OK;
					end
					fwkr_pkg::FN_POP, fwkr_pkg::FN_REMOVE, fwkr_pkg::FN_QUERY: begin
						res_status_q <= (count_q == '0) ? fwkr_pkg::STS_MISS
							: fwkr_pkg::STS_OK;
					end
					default: begin
						res_status_q <= fwkr_pkg::STS_OK;
					end
				endcase
			end
			S_POP: begin
				res_id_q <= ram_rdata;
			end
			S_SCAN: begin
				if (hit) begin
					idx_q <= cmp_idx_s1;
				end else if (cmp_idx_s1 == '0) begin
					res_status_q <= fwkr_pkg::STS_MISS;
				end else begin
					cmp_idx_s1 <= idx_q;
					idx_q      <= idx_q - PTR_W'(1);
				end
			end
			S_SHIFT: begin
				idx_q <= idx_q + PTR_W'(1);
			end
			S_DONE: begin
				if (out_load) begin
					out_status_q <= res_status_q;
					out_id_q     <= res_id_q;
					out_cnt_q    <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	`FWKR_ASSERT_IMPL(a_count_range, 1'b1, count_q <= FULL_CNT,
		"fill count above depth")
	`FWKR_ASSERT_IMPL(a_scan_nonempty, state_q == S_SCAN || state_q == S_SHIFT,
		count_q != '0, "search on empty queue")
	`FWKR_ASSERT_NEXT(a_pop_dec, state_q == S_POP,
		count_q == $past(count_q) - CNT_W'(1), "pop did not shrink queue")
	`FWKR_ASSERT_NEXT(a_push_inc,
		state_q == S_EXEC && func_q == fwkr_pkg::FN_PUSH && count_q != FULL_CNT,
		count_q == $past(count_q) + CNT_W'(1), "push did not grow queue")

endmodule
